// ----- sv/rpg_pkg.sv -----
// Shared constants for the rectangle pixel generator.
// Holds the configuration register indexes and fixed field widths; no dependencies.
package rpg_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Pen thickness is a fixed 8-bit field.
  localparam int THICK_BITS = 8;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [THICK_BITS-1:0]     thick_t;

  // Register indexes in the order of the register map.
  localparam cfg_index_t REG_CORNER_A_X  = 3'd0;
  localparam cfg_index_t REG_CORNER_A_Y  = 3'd1;
  localparam cfg_index_t REG_CORNER_B_X  = 3'd2;
  localparam cfg_index_t REG_CORNER_B_Y  = 3'd3;
  localparam cfg_index_t REG_SHAPE_COLOR = 3'd4;
  localparam cfg_index_t REG_PEN_WIDTH   = 3'd5;
  localparam cfg_index_t REG_FILL_ENABLE = 3'd6;

  // Reset pen width and the thickness used for interior pixels.
  localparam thick_t PEN_RESET      = 8'd1;
  localparam thick_t FILL_THICKNESS = 8'd1;

endpackage

// ----- sv/rpg_channels.sv -----
// Valid/ready channel interfaces of the rectangle pixel generator.
// Depends on rpg_pkg for the thickness width.
interface rpg_cmd_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rpg_pixel_if #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [COORD_BITS-1:0]       pixel_x;
  logic [COORD_BITS-1:0]       pixel_y;
  logic [COLOR_BITS-1:0]       pixel_color;
  logic [rpg_pkg::THICK_BITS-1:0] pixel_thickness;
  logic                        last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  output pixel_thickness, output last_pixel, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  input pixel_thickness, input last_pixel, output ready);
endinterface

// ----- sv/rpg_cfg.sv -----
// Configuration registers of the rectangle pixel generator, with corner ordering.
// Depends on rpg_pkg for register indexes and port widths.
module rpg_cfg #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic [COORD_BITS-1:0]              xmin,
  output logic [COORD_BITS-1:0]              xmax,
  output logic [COORD_BITS-1:0]              ymin,
  output logic [COORD_BITS-1:0]              ymax,
  output logic [COLOR_BITS-1:0]              color,
  output logic [rpg_pkg::THICK_BITS-1:0]     pen,
  output logic                               fill
);

  logic [COORD_BITS-1:0] corner_a_x;
  logic [COORD_BITS-1:0] corner_a_y;
  logic [COORD_BITS-1:0] corner_b_x;
  logic [COORD_BITS-1:0] corner_b_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a_x <= '0;
      corner_a_y <= '0;
      corner_b_x <= '0;
      corner_b_y <= '0;
      color      <= '0;
      pen        <= rpg_pkg::PEN_RESET;
      fill       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpg_pkg::REG_CORNER_A_X:  corner_a_x <= cfg_data[COORD_BITS-1:0];
        rpg_pkg::REG_CORNER_A_Y:  corner_a_y <= cfg_data[COORD_BITS-1:0];
        rpg_pkg::REG_CORNER_B_X:  corner_b_x <= cfg_data[COORD_BITS-1:0];
        rpg_pkg::REG_CORNER_B_Y:  corner_b_y <= cfg_data[COORD_BITS-1:0];
        rpg_pkg::REG_SHAPE_COLOR: color      <= cfg_data[COLOR_BITS-1:0];
        rpg_pkg::REG_PEN_WIDTH:   pen        <= cfg_data[rpg_pkg::THICK_BITS-1:0];
        rpg_pkg::REG_FILL_ENABLE: fill       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Order the two corners so the sequencer always walks upward.
  assign xmin = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
  assign xmax = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
  assign ymin = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
  assign ymax = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;

endmodule

// ----- sv/rpg_seq.sv -----
// Drawing sequencer: phase, column, row and pair counters that pick the next pixel.
// Depends on rpg_pkg for the thickness width and the fill thickness.
module rpg_seq #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           restart,
  input  logic [COORD_BITS-1:0]          xmin,
  input  logic [COORD_BITS-1:0]          xmax,
  input  logic [COORD_BITS-1:0]          ymin,
  input  logic [COORD_BITS-1:0]          ymax,
  input  logic [rpg_pkg::THICK_BITS-1:0] pen,
  input  logic                           fill,
  output logic                           emit,
  output logic [COORD_BITS-1:0]          px,
  output logic [COORD_BITS-1:0]          py,
  output logic [rpg_pkg::THICK_BITS-1:0] thick,
  output logic                           last
);

  localparam logic [1:0] PH_TB   = 2'd0;
  localparam logic [1:0] PH_LR   = 2'd1;
  localparam logic [1:0] PH_FILL = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] column_next;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] row_next;
  logic                  second;
  logic                  second_next;

  logic [1:0]            ph;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] rw;
  logic                  sec;
  logic                  has_interior;
  logic                  row_end;
  logic                  col_end;

  // Interior exists only when both spans are at least two.
  assign has_interior = ((xmax - xmin) >= COORD_BITS'(2)) && ((ymax - ymin) >= COORD_BITS'(2));

  always_comb begin
    ph  = phase;
    col = column;
    rw  = row;
    sec = second;
    if (restart) begin
      ph  = PH_TB;
      col = xmin;
      rw  = '0;
      sec = 1'b0;
    end
    // Fill end tests, done one bit wider so that the increment cannot wrap.
    row_end     = ({1'b0, rw} + (COORD_BITS+1)'(1)) >= {1'b0, ymax};
    col_end     = ({1'b0, col} + (COORD_BITS+1)'(1)) >= {1'b0, xmax};
    emit        = (ph != PH_DONE);
    px          = col;
    py          = rw;
    thick       = pen;
    phase_next  = ph;
    column_next = col;
    row_next    = rw;
    second_next = sec;
    unique case (ph)
      PH_TB: begin
        py = sec ? ymax : ymin;
        second_next = ~sec;
        if (sec) begin
          if (col >= xmax) begin
            phase_next = PH_LR;
            row_next   = ymin;
          end else begin
            column_next = col + COORD_BITS'(1);
          end
        end
      end
      PH_LR: begin
        px = sec ? xmax : xmin;
        second_next = ~sec;
        if (sec) begin
          if (rw >= ymax) begin
            if (fill && has_interior) begin
              phase_next  = PH_FILL;
              column_next = xmin + COORD_BITS'(1);
              row_next    = ymin + COORD_BITS'(1);
            end else begin
              phase_next = PH_DONE;
            end
          end else begin
            row_next = rw + COORD_BITS'(1);
          end
        end
      end
      PH_FILL: begin
        thick = rpg_pkg::FILL_THICKNESS;
        if (row_end) begin
          if (col_end) begin
            phase_next = PH_DONE;
          end else begin
            column_next = col + COORD_BITS'(1);
            row_next    = ymin + COORD_BITS'(1);
          end
        end else begin
          row_next = rw + COORD_BITS'(1);
        end
      end
      default: ;
    endcase
    last = (phase_next == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_DONE;
      column <= '0;
      row    <= '0;
      second <= 1'b0;
    end else if (step) begin
      phase  <= phase_next;
      column <= column_next;
      row    <= row_next;
      second <= second_next;
    end
  end

endmodule

// ----- sv/rectangle_pixel_generator.sv -----
// Rectangle pixel generator top level: configuration, sequencer and output register.
// Depends on rpg_pkg, rpg_channels (rpg_cmd_if, rpg_pixel_if), rpg_cfg and rpg_seq.
//
// Usage: software writes the two corners, the color, the pen width and the fill
// flag through the write port (cfg_we, cfg_index, cfg_data) while the block is idle.
// Each transfer on the cmd channel is one tick: restart = 1 starts a drawing and
// yields its first pixel, restart = 0 yields the next one. A tick either produces
// exactly one transfer on the pixel channel or, once the drawing is finished,
// nothing at all. The outline comes first (top and bottom per column, then left and
// right per row), then the interior when fill is on; last_pixel marks the end.
// The pixel for a tick is registered and is valid in the cycle after the cmd
// transfer. Throughput is one tick per cycle while the receiver does not stall,
// set by the sequencer counters stepping straight into the output register.
// Reset leaves the drawing finished, so advance ticks produce nothing until a
// restart; configuration returns to its reset values (pen width 1, all else 0).
// When the receiver stalls, the pending pixel is held in the output register and
// cmd.ready drops, so no tick is taken until that pixel has been transferred.
module rectangle_pixel_generator #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  rpg_cmd_if.sink                            cmd,
  rpg_pixel_if.source                        pixel,
  input  logic                               cfg_we,
  input  logic [rpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rpg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic [COORD_BITS-1:0]          xmin;
  logic [COORD_BITS-1:0]          xmax;
  logic [COORD_BITS-1:0]          ymin;
  logic [COORD_BITS-1:0]          ymax;
  logic [COLOR_BITS-1:0]          color;
  logic [rpg_pkg::THICK_BITS-1:0] pen;
  logic                           fill;

  logic                           step;
  logic                           emit;
  logic [COORD_BITS-1:0]          px;
  logic [COORD_BITS-1:0]          py;
  logic [rpg_pkg::THICK_BITS-1:0] thick;
  logic                           last;

  logic                           out_valid;

  rpg_cfg #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .xmin      (xmin),
    .xmax      (xmax),
    .ymin      (ymin),
    .ymax      (ymax),
    .color     (color),
    .pen       (pen),
    .fill      (fill)
  );

  // A tick is taken whenever the output register is empty or is being drained
  // in this same cycle, so back-to-back ticks flow at full rate.
  assign cmd.ready = ~out_valid | pixel.ready;
  assign step      = cmd.valid & cmd.ready;

  rpg_seq #(
    .COORD_BITS (COORD_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .restart (cmd.restart),
    .xmin    (xmin),
    .xmax    (xmax),
    .ymin    (ymin),
    .ymax    (ymax),
    .pen     (pen),
    .fill    (fill),
    .emit    (emit),
    .px      (px),
    .py      (py),
    .thick   (thick),
    .last    (last)
  );

  // Output register. A tick after the end of the drawing leaves it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= emit;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      pixel.pixel_x         <= px;
      pixel.pixel_y         <= py;
      pixel.pixel_color     <= color;
      pixel.pixel_thickness <= thick;
      pixel.last_pixel      <= last;
    end
  end

  assign pixel.valid = out_valid;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the rectangle pixel generator.
// Depends on rpg_pkg, on the channel interfaces in rpg_channels and on the top level.
// Walks a short table of ticks, then random drawings, against a cycle-free tracer.
module tb;

  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 32;
  localparam int COORD_MAX = (1 << COORD_W) - 1;

  // The register map leaves index 7 unused; writes to it must change nothing.
  localparam rpg_pkg::cfg_index_t REG_NONE = 3'd7;

  // Ticks to send in the random part.
  localparam int RANDOM_TICKS   = 1325;
  // Cycles to let pass once every expected pixel has arrived.
  localparam int SETTLE_CYCLES  = 4;
  // Cycles without any transfer or register write before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 400;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    coord_t          x;
    coord_t          y;
    color_t          color;
    rpg_pkg::thick_t thick;
    logic            last;
  } pixel_cmd_t;

  // One row of the directed table: either a register write or a tick. Typed rows carry
  // the pixel (or the absence of one) that can be read straight off the drawing order.
  typedef struct packed {
    logic                              is_cfg;
    rpg_pkg::cfg_index_t               idx;
    logic [rpg_pkg::CFG_DATA_BITS-1:0] data;
    logic                              restart;
    logic                              typed;
    logic                              yields;
    pixel_cmd_t                        pix;
  } plan_step_t;

  // Walk order of the tracer: top and bottom edges, left and right edges, interior, finished.
  typedef enum logic [1:0] {
    TRACE_TOP_BOTTOM,
    TRACE_LEFT_RIGHT,
    TRACE_FILL,
    TRACE_DONE
  } trace_phase_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_COMB,
    SINK_HOLDOFF
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic                              cfg_we;
  rpg_pkg::cfg_index_t               cfg_index;
  logic [rpg_pkg::CFG_DATA_BITS-1:0] cfg_data;

  rpg_cmd_if cmd_ch ();
  rpg_pixel_if #(.COORD_BITS(COORD_W), .COLOR_BITS(COLOR_W)) pix_ch ();

  rectangle_pixel_generator #(
    .COORD_BITS(COORD_W),
    .COLOR_BITS(COLOR_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .pixel     (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, starting at their reset values.
  coord_t          reg_ax    = '0;
  coord_t          reg_ay    = '0;
  coord_t          reg_bx    = '0;
  coord_t          reg_by    = '0;
  color_t          reg_color = '0;
  rpg_pkg::thick_t reg_pen   = rpg_pkg::PEN_RESET;
  logic            reg_fill  = 1'b0;

  // Tracer state. After reset the drawing counts as finished.
  trace_phase_t tr_phase  = TRACE_DONE;
  coord_t       tr_col    = '0;
  coord_t       tr_row    = '0;
  logic         tr_second = 1'b0;

  // Pixels the block owes, oldest first.
  pixel_cmd_t pixels_due[$];
  int mismatches = 0;
  int burst_left = 0;

  function automatic void apply_reg(rpg_pkg::cfg_index_t idx,
                                    logic [rpg_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      rpg_pkg::REG_CORNER_A_X:  reg_ax    = data[COORD_W-1:0];
      rpg_pkg::REG_CORNER_A_Y:  reg_ay    = data[COORD_W-1:0];
      rpg_pkg::REG_CORNER_B_X:  reg_bx    = data[COORD_W-1:0];
      rpg_pkg::REG_CORNER_B_Y:  reg_by    = data[COORD_W-1:0];
      rpg_pkg::REG_SHAPE_COLOR: reg_color = data[COLOR_W-1:0];
      rpg_pkg::REG_PEN_WIDTH:   reg_pen   = data[rpg_pkg::THICK_BITS-1:0];
      rpg_pkg::REG_FILL_ENABLE: reg_fill  = data[0];
      default: ;
    endcase
  endfunction

  // Advances the tracer by one tick. Returns 1 and the pixel if the tick yields one.
  // The registers are read live, so a change in the middle of a drawing bends it at once;
  // the end tests use >= so that a shrunken rectangle still terminates.
  function automatic bit next_pixel(input logic restart, output pixel_cmd_t pix);
    coord_t xmin, xmax, ymin, ymax;
    xmin = (reg_ax < reg_bx) ? reg_ax : reg_bx;
    xmax = (reg_ax < reg_bx) ? reg_bx : reg_ax;
    ymin = (reg_ay < reg_by) ? reg_ay : reg_by;
    ymax = (reg_ay < reg_by) ? reg_by : reg_ay;
    pix = '0;
    if (restart) begin
      tr_phase  = TRACE_TOP_BOTTOM;
      tr_col    = xmin;
      tr_row    = '0;
      tr_second = 1'b0;
    end
    if (tr_phase == TRACE_DONE) return 1'b0;
    pix.color = reg_color;
    pix.thick = reg_pen;
    case (tr_phase)
      TRACE_TOP_BOTTOM: begin
        pix.x = tr_col;
        pix.y = tr_second ? ymax : ymin;
        if (!tr_second) begin
          tr_second = 1'b1;
        end else begin
          tr_second = 1'b0;
          if (tr_col >= xmax) begin
            tr_phase = TRACE_LEFT_RIGHT;
            tr_row   = ymin;
          end else begin
            tr_col = tr_col + 1'b1;
          end
        end
      end
      TRACE_LEFT_RIGHT: begin
        pix.x = tr_second ? xmax : xmin;
        pix.y = tr_row;
        if (!tr_second) begin
          tr_second = 1'b1;
        end else begin
          tr_second = 1'b0;
          if (tr_row >= ymax) begin
            // The interior is only walked when it holds at least one pixel.
            if (reg_fill && (xmax - xmin) >= 2 && (ymax - ymin) >= 2) begin
              tr_phase = TRACE_FILL;
              tr_col   = xmin + 1'b1;
              tr_row   = ymin + 1'b1;
            end else begin
              tr_phase = TRACE_DONE;
            end
          end else begin
            tr_row = tr_row + 1'b1;
          end
        end
      end
      default: begin
        pix.x     = tr_col;
        pix.y     = tr_row;
        pix.thick = rpg_pkg::FILL_THICKNESS;
        // The current pixel always goes out before the end tests, which must not wrap.
        if ({1'b0, tr_row} + 1'b1 >= {1'b0, ymax}) begin
          if ({1'b0, tr_col} + 1'b1 >= {1'b0, xmax}) begin
            tr_phase = TRACE_DONE;
          end else begin
            tr_col = tr_col + 1'b1;
            tr_row = ymin + 1'b1;
          end
        end else begin
          tr_row = tr_row + 1'b1;
        end
      end
    endcase
    pix.last = (tr_phase == TRACE_DONE);
    return 1'b1;
  endfunction

  // Number of pixels in a full drawing under the current registers.
  function automatic int drawing_length();
    int w, h, n;
    w = int'(reg_ax) - int'(reg_bx);
    h = int'(reg_ay) - int'(reg_by);
    if (w < 0) w = -w;
    if (h < 0) h = -h;
    n = 2 * (w + 1) + 2 * (h + 1);
    if (reg_fill && w >= 2 && h >= 2) n += (w - 1) * (h - 1);
    return n;
  endfunction

  // A coordinate write with random junk above the register width.
  function automatic logic [rpg_pkg::CFG_DATA_BITS-1:0] noisy_coord(coord_t c);
    logic [rpg_pkg::CFG_DATA_BITS-1:0] d;
    d = $urandom;
    d[COORD_W-1:0] = c;
    return d;
  endfunction

  function automatic plan_step_t cfg_row(rpg_pkg::cfg_index_t idx,
                                         logic [rpg_pkg::CFG_DATA_BITS-1:0] data);
    plan_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    return s;
  endfunction

  // A tick whose outcome comes from the tracer.
  function automatic plan_step_t tick_row(logic restart);
    plan_step_t s;
    s = '0;
    s.restart = restart;
    return s;
  endfunction

  // A tick that must not produce a pixel.
  function automatic plan_step_t quiet_row(logic restart);
    plan_step_t s;
    s = '0;
    s.restart = restart;
    s.typed   = 1'b1;
    return s;
  endfunction

  // A tick with its pixel written out by hand.
  function automatic plan_step_t pixel_row(logic restart, coord_t x, coord_t y, color_t color,
                                           rpg_pkg::thick_t thick, logic last);
    plan_step_t s;
    s = '0;
    s.restart   = restart;
    s.typed     = 1'b1;
    s.yields    = 1'b1;
    s.pix.x     = x;
    s.pix.y     = y;
    s.pix.color = color;
    s.pix.thick = thick;
    s.pix.last  = last;
    return s;
  endfunction

  // Register writes go out back to back; the next tick lowers the write enable.
  task automatic write_reg(rpg_pkg::cfg_index_t idx, logic [rpg_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Offers one tick and returns at the clock edge where it is transferred. The sender
  // works in bursts: valid stays high across a burst and drops for a random gap between
  // bursts, with the occasional long burst so that stretches without idling occur too.
  task automatic send_tick(input logic restart);
    cfg_we <= 1'b0;
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
    end
    burst_left--;
    cmd_ch.valid   <= 1'b1;
    cmd_ch.restart <= restart;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Waits until every owed pixel has been transferred, then lets the output register drain
  // of anything a tick at the end of a drawing might still have in flight.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stalls on a pattern that is picked anew at random intervals. The open pattern
  // never stalls; the others stall at random, on a fixed comb, or in long holdoffs.
  initial begin : sink_stalls
    sink_mode_t mode;
    int mode_left;
    int cnt;
    pix_ch.ready <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    cnt       = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 200);
        cnt       = 0;
      end
      mode_left--;
      cnt++;
      case (mode)
        SINK_OPEN:    pix_ch.ready <= 1'b1;
        SINK_COIN:    pix_ch.ready <= 1'($urandom_range(0, 1));
        SINK_COMB:    pix_ch.ready <= (cnt % 5) < 3;
        SINK_HOLDOFF: pix_ch.ready <= (cnt % 16) < 10;
        default:      pix_ch.ready <= 1'b1;
      endcase
    end
  end

  // Every pixel transfer is checked against the oldest owed pixel, field by field.
  always @(posedge clk) begin : pixel_check
    pixel_cmd_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel at (%0d,%0d) transferred with no tick owing it",
               pix_ch.pixel_x, pix_ch.pixel_y);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        if (pix_ch.pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, pix_ch.pixel_x);
          mismatches++;
        end
        if (pix_ch.pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, pix_ch.pixel_y);
          mismatches++;
        end
        if (pix_ch.pixel_color !== want.color) begin
          $error("pixel_color: expected %08h, got %08h", want.color, pix_ch.pixel_color);
          mismatches++;
        end
        if (pix_ch.pixel_thickness !== want.thick) begin
          $error("pixel_thickness: expected %0d, got %0d", want.thick, pix_ch.pixel_thickness);
          mismatches++;
        end
        if (pix_ch.last_pixel !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, pix_ch.last_pixel);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: any transfer on either channel or any register write counts as progress.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    plan_step_t plan[$];
    plan_step_t step;
    pixel_cmd_t pix;
    logic       prev_cfg;
    logic       restart;
    logic       first;
    bit         big;
    bit         swap;
    int         span;
    int         len;
    int         ticks;
    int         random_ticks;
    coord_t     lo_x, hi_x, lo_y, hi_y;
    logic [rpg_pkg::CFG_DATA_BITS-1:0] d;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= rpg_pkg::REG_CORNER_A_X;
    cfg_data       <= '0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.restart <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    plan = '{
      // Out of reset the drawing is finished, so an advance yields nothing.
      quiet_row(1'b0),
      // Reset registers: all corners at the origin, so every pair collapses onto (0,0).
      pixel_row(1'b1, 12'd0, 12'd0, 32'h0, rpg_pkg::PEN_RESET, 1'b0),
      pixel_row(1'b0, 12'd0, 12'd0, 32'h0, rpg_pkg::PEN_RESET, 1'b0),
      pixel_row(1'b0, 12'd0, 12'd0, 32'h0, rpg_pkg::PEN_RESET, 1'b0),
      pixel_row(1'b0, 12'd0, 12'd0, 32'h0, rpg_pkg::PEN_RESET, 1'b1),
      quiet_row(1'b0),
      // Corner A at the far end of the canvas, B two steps in, so the corners arrive
      // swapped. Junk above the register widths must be dropped, and the unused index
      // must be ignored.
      cfg_row(rpg_pkg::REG_CORNER_A_X, 32'hFFFF_FFFF),
      cfg_row(rpg_pkg::REG_CORNER_A_Y, 32'hFFFF_FFFF),
      cfg_row(rpg_pkg::REG_CORNER_B_X, 32'd4093),
      cfg_row(rpg_pkg::REG_CORNER_B_Y, 32'd4093),
      cfg_row(rpg_pkg::REG_SHAPE_COLOR, 32'hFFFF_FFFF),
      cfg_row(rpg_pkg::REG_PEN_WIDTH, 32'hFFFF_FFFF),
      cfg_row(rpg_pkg::REG_FILL_ENABLE, 32'hFFFF_FFFF),
      cfg_row(REG_NONE, 32'h0),
      pixel_row(1'b1, 12'd4093, 12'd4093, 32'hFFFF_FFFF, 8'd255, 1'b0),
      tick_row(1'b0), tick_row(1'b0), tick_row(1'b0), tick_row(1'b0),
      tick_row(1'b0), tick_row(1'b0), tick_row(1'b0), tick_row(1'b0),
      tick_row(1'b0), tick_row(1'b0), tick_row(1'b0),
      // The single interior pixel closes the drawing at fill thickness.
      pixel_row(1'b0, 12'd4094, 12'd4094, 32'hFFFF_FFFF, rpg_pkg::FILL_THICKNESS, 1'b1),
      quiet_row(1'b0),
      // A full-height line with zero color and a zero pen, restarted part way through.
      cfg_row(rpg_pkg::REG_CORNER_A_X, 32'd0),
      cfg_row(rpg_pkg::REG_CORNER_A_Y, 32'd0),
      cfg_row(rpg_pkg::REG_CORNER_B_X, 32'd0),
      cfg_row(rpg_pkg::REG_CORNER_B_Y, 32'd4095),
      cfg_row(rpg_pkg::REG_SHAPE_COLOR, 32'h0),
      cfg_row(rpg_pkg::REG_PEN_WIDTH, 32'h0),
      cfg_row(rpg_pkg::REG_FILL_ENABLE, 32'h0),
      pixel_row(1'b1, 12'd0, 12'd0, 32'h0, 8'd0, 1'b0),
      pixel_row(1'b0, 12'd0, 12'd4095, 32'h0, 8'd0, 1'b0),
      tick_row(1'b1),
      tick_row(1'b0)
    };

    // Directed part. Registers are only written once the block has drained.
    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      step = plan[i];
      if (step.is_cfg) begin
        if (!prev_cfg) settle();
        write_reg(step.idx, step.data);
      end else begin
        send_tick(step.restart);
        if (!step.typed) begin
          if (next_pixel(step.restart, pix)) pixels_due.push_back(pix);
        end else begin
          // The tracer still has to follow along; the hand-written pixel is what is owed.
          void'(next_pixel(step.restart, pix));
          if (step.yields) pixels_due.push_back(step.pix);
        end
      end
      prev_cfg = step.is_cfg;
    end

    // Random part: each round drains the block, rewrites some registers and then runs a
    // drawing with random content. Most rectangles are small so that they finish, with a
    // few spanning the canvas that are cut short. Some rounds carry on from where the last
    // one left off under the new registers, and now and then a restart lands mid-drawing.
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      settle();
      big = ($urandom_range(0, 11) == 0);
      if (big || $urandom_range(0, 7) != 0) begin
        span = $urandom_range(0, 6);
        lo_x = coord_t'($urandom_range(0, COORD_MAX - span));
        hi_x = big ? coord_t'($urandom) : lo_x + coord_t'(span);
        span = $urandom_range(0, 6);
        lo_y = coord_t'($urandom_range(0, COORD_MAX - span));
        hi_y = big ? coord_t'($urandom) : lo_y + coord_t'(span);
        swap = 1'($urandom_range(0, 1));
        write_reg(rpg_pkg::REG_CORNER_A_X, noisy_coord(swap ? hi_x : lo_x));
        write_reg(rpg_pkg::REG_CORNER_B_X, noisy_coord(swap ? lo_x : hi_x));
        swap = 1'($urandom_range(0, 1));
        write_reg(rpg_pkg::REG_CORNER_A_Y, noisy_coord(swap ? hi_y : lo_y));
        write_reg(rpg_pkg::REG_CORNER_B_Y, noisy_coord(swap ? lo_y : hi_y));
      end
      if ($urandom_range(0, 1)) write_reg(rpg_pkg::REG_SHAPE_COLOR, $urandom);
      if ($urandom_range(0, 1)) begin
        d = $urandom;
        if ($urandom_range(0, 3) == 0)
          d[rpg_pkg::THICK_BITS-1:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        write_reg(rpg_pkg::REG_PEN_WIDTH, d);
      end
      if ($urandom_range(0, 1)) write_reg(rpg_pkg::REG_FILL_ENABLE, $urandom);
      if ($urandom_range(0, 15) == 0) write_reg(REG_NONE, $urandom);

      // Run a little past the end of a short drawing so that finished-state ticks occur.
      len   = drawing_length();
      ticks = (len <= 80) ? len + $urandom_range(0, 3) : $urandom_range(10, 40);
      first = ($urandom_range(0, 5) != 0);
      for (int t = 0; t < ticks; t++) begin
        restart = (t == 0) ? first : ($urandom_range(0, 39) == 0);
        send_tick(restart);
        random_ticks++;
        if (next_pixel(restart, pix)) pixels_due.push_back(pix);
      end
    end

    settle();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/rpg_pkg.sv
sv/rpg_channels.sv
sv/rpg_cfg.sv
sv/rpg_seq.sv
sv/rectangle_pixel_generator.sv
tb/sv/tb.sv
